// ===== hw/rtl/differential_steering_pd_macros.svh =====
// Assertion macros for the differential steering PD controller.
// Used by differential_steering_pd.sv, the RTL file that carries concurrent assertions; needs no package.
`ifndef DIFFERENTIAL_STEERING_PD_MACROS_SVH
`define DIFFERENTIAL_STEERING_PD_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSPD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DSPD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dspd_pkg.sv =====
// Shared types and constants of the differential steering PD controller.
// Used by the shared divider, the top level and the testbench; depends on nothing.
package dspd_pkg;

  localparam int unsigned DivW   = 48;
  localparam int unsigned DvsW   = 16;
  localparam int unsigned DivCntW = 6;

  localparam logic [2:0] RegGainP   = 3'd0;
  localparam logic [2:0] RegGainD   = 3'd1;
  localparam logic [2:0] RegSumMin  = 3'd2;
  localparam logic [2:0] RegGyroOff = 3'd3;
  localparam logic [2:0] RegPeriod  = 3'd4;

  localparam logic CmdUpdate = 1'b0;
  localparam logic CmdTick   = 1'b1;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DvsW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [DivW-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== hw/rtl/differential_steering_pd.sv =====
// Differential steering PD controller with interpolated output ramp.
// Depends on dspd_pkg, dspd_div and differential_steering_pd_macros.svh.
//
// An update transfer (cmd 0) sets a new steering target from the halved
// sensor sums and the gyro rate; a tick transfer (cmd 1) returns a value on
// the ramp from the previous to the new target. Each input transfer gives
// exactly one result transfer. One item is worked on at a time. Both kinds of
// item pass through the shared 48-step divider, whose steps take most of
// their time. An update with a zero sensor total and a zero sum_minimum skips
// the divider; one whose halved sum is below sum_minimum goes straight to the
// output state with a zero result. The input is ready again in the cycle the
// result becomes valid.
// A waiting result sits in the output register while the next item is taken.
`include "differential_steering_pd_macros.svh"

module differential_steering_pd (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [15:0] left_sum_i,
  input  logic [15:0] right_sum_i,
  input  logic signed [15:0] gyro_rate_i,
  input  logic [5:0]  phase_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [31:0] drive_o,
  output logic        saturated_o
);
  import dspd_pkg::*;

  typedef struct packed {
    logic signed [31:0] val;
    logic               sat;
  } sat_t;

  localparam logic signed [49:0] RailHi = 50'sd2147483647;
  localparam logic signed [49:0] RailLo = -50'sd2147483648;

  function automatic sat_t sat32(input logic signed [49:0] x);
    sat_t r;
    r.val = x[31:0];
    r.sat = 1'b0;
    if (x > RailHi) begin
      r.val = 32'sh7fffffff;
      r.sat = 1'b1;
    end else if (x < RailLo) begin
      r.val = 32'sh80000000;
      r.sat = 1'b1;
    end
    return r;
  endfunction

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_DST  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_MULD = 3'd4;
  localparam logic [2:0] S_FINU = 3'd5;
  localparam logic [2:0] S_FINT = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state_q, state_d;

  logic signed [31:0] gain_p_q, gain_d_q;
  logic [15:0]        sum_min_q;
  logic signed [15:0] gyro_off_q;
  logic [6:0]         period_q;

  logic signed [31:0] target_old_q, target_old_d;
  logic signed [31:0] target_new_q, target_new_d;

  logic               cmd_q, cmd_d;
  logic signed [15:0] sub_q, sub_d;
  logic signed [16:0] g_q, g_d;
  logic [15:0]        add_q, add_d;
  logic [6:0]         ph1_q, ph1_d;
  logic [6:0]         per_q, per_d;
  logic signed [49:0] prod_q, prod_d;
  logic               neg_q, neg_d;
  logic signed [48:0] q_q, q_d;
  logic signed [31:0] res_drive_q, res_drive_d;
  logic               res_sat_q, res_sat_d;

  logic               out_valid_q, out_valid_d;
  logic signed [31:0] drive_q, drive_d;
  logic               sat_q, sat_d;

  logic               in_xfer, out_load;
  logic [15:0]        l_half, r_half;
  logic [6:0]         per_eff, ph_eff;
  logic signed [32:0] diff, mul_a;
  logic signed [16:0] mul_b;
  logic signed [49:0] mul_p;
  logic [49:0]        prod_mag;
  logic [48:0]        quo_ext;
  sat_t               p_term, d_term, u_sum, t_val;

  div_req_t div_req;
  div_rsp_t div_rsp;

  dspd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  assign l_half  = {1'b0, left_sum_i[15:1]};
  assign r_half  = {1'b0, right_sum_i[15:1]};
  assign per_eff = (period_q == 7'd0) ? 7'd1 : period_q;
  assign ph_eff  = ({1'b0, phase_i} > (per_eff - 7'd1)) ? (per_eff - 7'd1) : {1'b0, phase_i};

  assign diff = {target_new_q[31], target_new_q} - {target_old_q[31], target_old_q};

  always_comb begin
    if (state_q == S_MULD) begin
      mul_a = {gain_d_q[31], gain_d_q};
      mul_b = g_q;
    end else if (cmd_q == CmdTick) begin
      mul_a = diff;
      mul_b = {10'd0, ph1_q};
    end else begin
      mul_a = {gain_p_q[31], gain_p_q};
      mul_b = {sub_q[15], sub_q};
    end
  end

  assign mul_p    = mul_a * mul_b;
  assign prod_mag = prod_q[49] ? 50'(-prod_q) : 50'(prod_q);
  assign quo_ext  = {1'b0, div_rsp.quotient};

  assign p_term = sat32({q_q[48], q_q});
  assign d_term = sat32(prod_q);
  assign u_sum  = sat32({{18{p_term.val[31]}}, p_term.val} + {{18{d_term.val[31]}}, d_term.val});
  assign t_val  = sat32({q_q[48], q_q} + {{18{target_old_q[31]}}, target_old_q});

  assign div_req.start    = (state_q == S_DST) && ((cmd_q == CmdTick) || (add_q != 16'd0));
  assign div_req.dividend = prod_mag[DivW-1:0];
  assign div_req.divisor  = (cmd_q == CmdTick) ? {9'd0, per_q} : add_q;

  always_comb begin
    state_d      = state_q;
    target_old_d = target_old_q;
    target_new_d = target_new_q;
    cmd_d        = cmd_q;
    sub_d        = sub_q;
    g_d          = g_q;
    add_d        = add_q;
    ph1_d        = ph1_q;
    per_d        = per_q;
    prod_d       = prod_q;
    neg_d        = neg_q;
    q_d          = q_q;
    res_drive_d  = res_drive_q;
    res_sat_d    = res_sat_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          cmd_d = cmd_i;
          sub_d = l_half - r_half;
          add_d = l_half + r_half;
          g_d   = {gyro_rate_i[15], gyro_rate_i} - {gyro_off_q[15], gyro_off_q};
          ph1_d = ph_eff + 7'd1;
          per_d = per_eff;
          if (cmd_i == CmdTick) begin
            state_d = S_MUL1;
          end else begin
            target_old_d = target_new_q;
            if ((l_half + r_half) < sum_min_q) begin
              target_new_d = '0;
              res_drive_d  = '0;
              res_sat_d    = 1'b0;
              state_d      = S_OUT;
            end else begin
              state_d = S_MUL1;
            end
          end
        end
      end
      S_MUL1: begin
        prod_d  = mul_p;
        state_d = S_DST;
      end
      S_DST: begin
        neg_d = prod_q[49];
        if (div_req.start) begin
          state_d = S_DIV;
        end else begin
          q_d     = '0;
          state_d = S_MULD;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          q_d     = neg_q ? 49'(-quo_ext) : 49'(quo_ext);
          state_d = (cmd_q == CmdTick) ? S_FINT : S_MULD;
        end
      end
      S_MULD: begin
        prod_d  = mul_p;
        state_d = S_FINU;
      end
      S_FINU: begin
        target_new_d = u_sum.val;
        res_drive_d  = u_sum.val;
        res_sat_d    = p_term.sat | d_term.sat | u_sum.sat;
        state_d      = S_OUT;
      end
      S_FINT: begin
        res_drive_d = t_val.val;
        res_sat_d   = t_val.sat;
        state_d     = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    drive_d     = drive_q;
    sat_d       = sat_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      drive_d     = res_drive_q;
      sat_d       = res_sat_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      target_old_q <= '0;
      target_new_q <= '0;
      gain_p_q     <= 32'sd32768;
      gain_d_q     <= 32'sd655;
      sum_min_q    <= 16'd100;
      gyro_off_q   <= '0;
      period_q     <= 7'd20;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      target_old_q <= target_old_d;
      target_new_q <= target_new_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          RegGainP:   gain_p_q   <= cfg_data_i;
          RegGainD:   gain_d_q   <= cfg_data_i;
          RegSumMin:  sum_min_q  <= cfg_data_i[15:0];
          RegGyroOff: gyro_off_q <= cfg_data_i[15:0];
          RegPeriod:  period_q   <= cfg_data_i[6:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    sub_q       <= sub_d;
    g_q         <= g_d;
    add_q       <= add_d;
    ph1_q       <= ph1_d;
    per_q       <= per_d;
    prod_q      <= prod_d;
    neg_q       <= neg_d;
    q_q         <= q_d;
    res_drive_q <= res_drive_d;
    res_sat_q   <= res_sat_d;
    drive_q     <= drive_d;
    sat_q       <= sat_d;
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;
  assign saturated_o = sat_q;

  `DSPD_ASSERT_IMP(a_ready_div_idle, in_ready_o, !div_rsp.busy, "input ready while divider busy")
  `DSPD_ASSERT_IMP(a_done_in_div, div_rsp.done, state_q == S_DIV, "divider done outside wait state")
  `DSPD_ASSERT_NXT(a_accept_busy, in_xfer, !in_ready_o, "input ready right after a transfer")
  `DSPD_ASSERT_NXT(a_tick_keeps_target, in_xfer && (cmd_i == CmdTick),
                   target_new_q == $past(target_new_q) && target_old_q == $past(target_old_q),
                   "tick changed the targets")

endmodule

// ===== hw/rtl/dspd_div.sv =====
// Shared unsigned restoring divider, one quotient bit per cycle.
// Depends on dspd_pkg for the request and response types.
module dspd_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dspd_pkg::div_req_t req_i,
  output dspd_pkg::div_rsp_t rsp_o
);
  import dspd_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DvsW-1:0]    rem_q, rem_d;
  logic [DivW-1:0]    quo_q, quo_d;
  logic [DvsW-1:0]    dvs_q, dvs_d;
  logic [DvsW:0]      shifted;
  logic [DvsW+1:0]    trial;
  logic               fits;

  assign shifted = {rem_q, quo_q[DivW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_q};
  assign fits    = !trial[DvsW+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DivCntW'(DivW);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? trial[DvsW-1:0] : shifted[DvsW-1:0];
      quo_d = {quo_q[DivW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== tb/differential_steering_pd_tb.sv =====
// Self-checking testbench for the differential steering PD controller.
// A directed table and then random phases run against a built-in predictor.
// Depends on dspd_pkg and on the differential_steering_pd RTL.
module differential_steering_pd_tb;
  import dspd_pkg::RegGainP;
  import dspd_pkg::RegGainD;
  import dspd_pkg::RegSumMin;
  import dspd_pkg::RegGyroOff;
  import dspd_pkg::RegPeriod;
  import dspd_pkg::CmdUpdate;
  import dspd_pkg::CmdTick;

  localparam longint RailHi = 64'sd2147483647;
  localparam longint RailLo = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               sat;
  } drive_exp_t;

  typedef struct packed {
    logic        is_cfg;
    logic [2:0]  reg_idx;
    logic [31:0] reg_data;
    logic        cmd;
    logic [15:0] left;
    logic [15:0] right;
    logic [15:0] gyro;
    logic [5:0]  phase;
    logic        known;
    logic [31:0] drive;
    logic        sat;
  } stim_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [2:0]         cfg_index_i;
  logic [31:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               cmd_i;
  logic [15:0]        left_sum_i;
  logic [15:0]        right_sum_i;
  logic signed [15:0] gyro_rate_i;
  logic [5:0]         phase_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [31:0] drive_o;
  logic               saturated_o;

  logic signed [31:0] cfg_gain_p;
  logic signed [31:0] cfg_gain_d;
  logic [15:0]        cfg_sum_min;
  logic signed [15:0] cfg_gyro_off;
  logic [6:0]         cfg_period;
  logic signed [31:0] tgt_old;
  logic signed [31:0] tgt_new;

  drive_exp_t drive_exp_q[$];
  stim_row_t  stim_table[$];
  int mismatches   = 0;
  int results_seen = 0;
  int sat_seen     = 0;
  int updates_sent = 0;
  int ticks_sent   = 0;
  int settings_run = 1;

  differential_steering_pd uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .left_sum_i  (left_sum_i),
    .right_sum_i (right_sum_i),
    .gyro_rate_i (gyro_rate_i),
    .phase_i     (phase_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .drive_o     (drive_o),
    .saturated_o (saturated_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [32:0] clamp32(input longint x);
    if (x > RailHi) begin
      return {1'b1, 32'h7FFF_FFFF};
    end
    if (x < RailLo) begin
      return {1'b1, 32'h8000_0000};
    end
    return {1'b0, x[31:0]};
  endfunction

  task automatic steer_predict(input logic cmd, input logic [15:0] left,
                               input logic [15:0] right, input logic signed [15:0] gyro,
                               input logic [5:0] phase, output drive_exp_t res);
    longint l, r, add, sub, g, period, ph, diff, min_v;
    logic [32:0] c;
    logic sat;
    logic signed [31:0] pt, dt;
    sat = 1'b0;
    if (cmd == CmdUpdate) begin
      l = longint'(left >> 1);
      r = longint'(right >> 1);
      add = l + r;
      sub = l - r;
      min_v = longint'(cfg_sum_min);
      tgt_old = tgt_new;
      if (add < min_v) begin
        tgt_new = '0;
      end else begin
        pt = '0;
        if (add != 0) begin
          c = clamp32((sub * longint'(cfg_gain_p)) / add);
          sat |= c[32];
          pt = c[31:0];
        end
        g = longint'(gyro) - longint'(cfg_gyro_off);
        c = clamp32(g * longint'(cfg_gain_d));
        sat |= c[32];
        dt = c[31:0];
        c = clamp32(longint'(pt) + longint'(dt));
        sat |= c[32];
        tgt_new = c[31:0];
      end
      res.drive = tgt_new;
    end else begin
      period = longint'(cfg_period);
      if (period == 0) begin
        period = 1;
      end
      ph = longint'(phase);
      if (ph > period - 1) begin
        ph = period - 1;
      end
      diff = longint'(tgt_new) - longint'(tgt_old);
      c = clamp32((diff * (ph + 1)) / period + longint'(tgt_old));
      sat |= c[32];
      res.drive = c[31:0];
    end
    res.sat = sat;
  endtask

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) begin
      return 0;
    end
    if (k < 90) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(10, 80);
  endfunction

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(0, 6))
      0: return 32'd32768;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return $urandom;
      default: return 32'($urandom_range(0, 32'h1F_FFFF)) - 32'h10_0000;
    endcase
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegGainP:   cfg_gain_p   = data;
      RegGainD:   cfg_gain_d   = data;
      RegSumMin:  cfg_sum_min  = data[15:0];
      RegGyroOff: cfg_gyro_off = data[15:0];
      RegPeriod:  cfg_period   = data[6:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (drive_exp_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic send_item(input logic cmd, input logic [15:0] left, input logic [15:0] right,
                           input logic [15:0] gyro, input logic [5:0] phase,
                           input logic known, input logic [31:0] k_drive, input logic k_sat);
    drive_exp_t e;
    int gap;
    in_valid_i  <= 1'b1;
    cmd_i       <= cmd;
    left_sum_i  <= left;
    right_sum_i <= right;
    gyro_rate_i <= gyro;
    phase_i     <= phase;
    do @(posedge clk_i); while (!in_ready_o);
    steer_predict(cmd, left, right, gyro, phase, e);
    if (known) begin
      e.drive = k_drive;
      e.sat   = k_sat;
    end
    drive_exp_q.push_back(e);
    if (cmd == CmdUpdate) begin
      updates_sent++;
    end else begin
      ticks_sent++;
    end
    @(negedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic random_item();
    logic [15:0] left, right;
    left  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 300)) : 16'($urandom);
    right = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 300)) : 16'($urandom);
    send_item(1'($urandom_range(0, 1)), left, right, 16'($urandom),
              6'($urandom_range(0, 63)), 1'b0, '0, 1'b0);
  endtask

  task automatic row_cfg(input logic [2:0] idx, input logic [31:0] data);
    stim_row_t row;
    row = '0;
    row.is_cfg   = 1'b1;
    row.reg_idx  = idx;
    row.reg_data = data;
    stim_table.push_back(row);
  endtask

  task automatic row_item(input logic cmd, input logic [15:0] left, input logic [15:0] right,
                          input logic [15:0] gyro, input logic [5:0] phase,
                          input logic known, input logic [31:0] drive, input logic sat);
    stim_row_t row;
    row = '{1'b0, 3'd0, 32'd0, cmd, left, right, gyro, phase, known, drive, sat};
    stim_table.push_back(row);
  endtask

  initial begin : result_check
    drive_exp_t e;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        results_seen++;
        if (saturated_o) begin
          sat_seen++;
        end
        if (drive_exp_q.size() == 0) begin
          $error("unexpected result transfer: drive %0d saturated %0d", drive_o, saturated_o);
          mismatches++;
        end else begin
          e = drive_exp_q.pop_front();
          if (drive_o !== e.drive) begin
            $error("drive: expected %0d, actual %0d", e.drive, drive_o);
            mismatches++;
          end
          if (saturated_o !== e.sat) begin
            $error("saturated: expected %0d, actual %0d", e.sat, saturated_o);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin : result_ready
    int stall;
    bit held;
    held = 1'b0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 40)) @(negedge clk_i);
      stall = pick_gap();
      if (!held && results_seen >= 150) begin
        stall = 600;
        held  = 1'b1;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
    end
  end

  initial begin : stimulus
    stim_row_t row;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    cmd_i        = CmdUpdate;
    left_sum_i   = '0;
    right_sum_i  = '0;
    gyro_rate_i  = '0;
    phase_i      = '0;
    cfg_gain_p   = 32'sd32768;
    cfg_gain_d   = 32'sd655;
    cfg_sum_min  = 16'd100;
    cfg_gyro_off = '0;
    cfg_period   = 7'd20;
    tgt_old      = '0;
    tgt_new      = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    row_item(CmdTick,   16'd0,     16'd0,     16'sd0,      6'd0,  1'b1, 32'd0, 1'b0);
    row_item(CmdUpdate, 16'd0,     16'd0,     16'sd0,      6'd0,  1'b1, 32'd0, 1'b0);
    row_item(CmdUpdate, 16'hFFFF,  16'd0,     16'sd0,      6'd0,  1'b1, 32'd32768, 1'b0);
    row_item(CmdTick,   16'd0,     16'd0,     16'sd0,      6'd63, 1'b0, '0, 1'b0);
    row_item(CmdUpdate, 16'd0,     16'hFFFF,  16'sd0,      6'd0,  1'b1, 32'hFFFF_8000, 1'b0);
    row_item(CmdTick,   16'd0,     16'd0,     16'sd0,      6'd0,  1'b0, '0, 1'b0);
    row_item(CmdUpdate, 16'hFFFF,  16'hFFFF,  16'sh7FFF,   6'd0,  1'b0, '0, 1'b0);
    row_item(CmdUpdate, 16'hFFFF,  16'hFFFF,  16'sh8000,   6'd0,  1'b0, '0, 1'b0);
    row_item(CmdUpdate, 16'd1,     16'd1,     16'sh7FFF,   6'd0,  1'b1, 32'd0, 1'b0);
    row_cfg(RegGainP,   32'h7FFF_FFFF);
    row_cfg(RegGainD,   32'h7FFF_FFFF);
    row_cfg(RegSumMin,  32'd0);
    row_cfg(RegGyroOff, 32'h0000_8000);
    row_cfg(RegPeriod,  32'd0);
    row_item(CmdUpdate, 16'd0,     16'd0,     16'sd0,      6'd0,  1'b1, 32'h7FFF_FFFF, 1'b1);
    row_item(CmdUpdate, 16'hFFFF,  16'd0,     16'sh7FFF,   6'd0,  1'b1, 32'h7FFF_FFFF, 1'b1);
    row_item(CmdTick,   16'd0,     16'd0,     16'sd0,      6'd5,  1'b0, '0, 1'b0);
    row_item(CmdUpdate, 16'd0,     16'hFFFF,  16'sh8000,   6'd0,  1'b0, '0, 1'b0);
    row_item(CmdTick,   16'd0,     16'd0,     16'sd0,      6'd0,  1'b0, '0, 1'b0);
    row_cfg(RegGainP,   32'h8000_0000);
    row_cfg(RegGainD,   32'h8000_0000);
    row_cfg(RegSumMin,  32'h0000_FFFF);
    row_cfg(RegGyroOff, 32'h0000_7FFF);
    row_cfg(RegPeriod,  32'd127);
    row_item(CmdUpdate, 16'hFFFF,  16'hFFFF,  16'sd0,      6'd0,  1'b1, 32'd0, 1'b0);
    row_item(CmdTick,   16'd0,     16'd0,     16'sd0,      6'd63, 1'b0, '0, 1'b0);
    row_cfg(RegSumMin,  32'd0);
    row_cfg(RegPeriod,  32'd64);
    row_item(CmdUpdate, 16'd0,     16'hFFFF,  16'sh8000,   6'd0,  1'b1, 32'h7FFF_FFFF, 1'b1);
    row_item(CmdUpdate, 16'hFFFF,  16'd0,     16'sh7FFF,   6'd0,  1'b0, '0, 1'b0);
    row_item(CmdTick,   16'd0,     16'd0,     16'sd0,      6'd63, 1'b0, '0, 1'b0);
    row_item(CmdTick,   16'd0,     16'd0,     16'sd0,      6'd31, 1'b0, '0, 1'b0);
    row_item(CmdUpdate, 16'd2,     16'd3,     16'sd1,      6'd0,  1'b0, '0, 1'b0);
    row_cfg(RegPeriod,  32'd1);
    row_item(CmdTick,   16'd0,     16'd0,     16'sd0,      6'd0,  1'b0, '0, 1'b0);

    foreach (stim_table[i]) begin
      row = stim_table[i];
      if (row.is_cfg) begin
        drain();
        write_reg(row.reg_idx, row.reg_data);
      end else begin
        send_item(row.cmd, row.left, row.right, row.gyro, row.phase,
                  row.known, row.drive, row.sat);
      end
    end
    settings_run += 4;

    for (int p = 0; p < 8; p++) begin
      drain();
      write_reg(RegGainP, rand_gain());
      write_reg(RegGainD, rand_gain());
      case ($urandom_range(0, 3))
        0: write_reg(RegSumMin, 32'd0);
        1: write_reg(RegSumMin, 32'h0000_FFFF);
        default: write_reg(RegSumMin, 32'($urandom_range(0, 400)));
      endcase
      write_reg(RegGyroOff, ($urandom_range(0, 1) == 0) ? 32'd0 : 32'($urandom_range(0, 65535)));
      case ($urandom_range(0, 5))
        0: write_reg(RegPeriod, 32'd0);
        1: write_reg(RegPeriod, 32'd127);
        2: write_reg(RegPeriod, 32'd64);
        3: write_reg(RegPeriod, 32'd1);
        default: write_reg(RegPeriod, 32'($urandom_range(1, 64)));
      endcase
      settings_run++;
      repeat (250) random_item();
    end

    drain();
    repeat (100) @(negedge clk_i);
    $display("Run covered %0d updates and %0d ticks over %0d register settings.",
             updates_sent, ticks_sent, settings_run);
    $display("%0d result transfers were checked, %0d of them saturated.",
             results_seen, sat_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/dspd_pkg.sv
hw/rtl/dspd_div.sv
hw/rtl/differential_steering_pd.sv
tb/differential_steering_pd_tb.sv
